// ----- rtl/core/sbit_pkg.sv -----
// Shared types and constants for the segment/box intersection test unit.
package sbit_pkg;

	typedef enum logic [1:0] {
		ACT_SEG_SEG = 2'd0,
		ACT_BOX_SEG = 2'd1,
		ACT_BOX_BOX = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	// Orientation sign: positive and negative flags, both low for zero.
	typedef struct packed {
		logic pos;
		logic neg;
	} osign_t;

	// Control word that travels beside the coordinate data.
	typedef struct packed {
		action_t act;
		logic    bad;
		logic    inbox;
	} ctl_t;

endpackage

// ----- rtl/core/segment_box_intersection_test.sv -----
// Top level of the segment/box intersection test unit.
// Register stages from input beat to output beat: operand diff, product, sign/result.
// Throughput: one beat per cycle while not stalled; the five segment units are fully pipelined.
// Stall freezes all stages together; a valid output can still be replaced when
// stall is low and a new beat arrives behind it.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
module segment_box_intersection_test #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   action,
	input  logic signed [COORD_BITS-1:0] first_x0,
	input  logic signed [COORD_BITS-1:0] first_y0,
	input  logic signed [COORD_BITS-1:0] first_x1,
	input  logic signed [COORD_BITS-1:0] first_y1,
	input  logic signed [COORD_BITS-1:0] second_x0,
	input  logic signed [COORD_BITS-1:0] second_y0,
	input  logic signed [COORD_BITS-1:0] second_x1,
	input  logic signed [COORD_BITS-1:0] second_y1,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic                         bad_box
);
	import sbit_pkg::*;

	localparam int CW = COORD_BITS;

	logic v_s1, v_s2, v_s3, adv;
	ctl_t c_in, c_s1, c_s2;
	logic [4:0] seg_hit;
	logic hit_s3, bad_s3;
	logic signed [CW-1:0] ex0 [4];
	logic signed [CW-1:0] ey0 [4];
	logic signed [CW-1:0] ex1 [4];
	logic signed [CW-1:0] ey1 [4];
	logic any;

	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Box edges for the box-segment test.
	assign ex0 = '{second_x0, second_x1, second_x1, second_x0};
	assign ey0 = '{second_y0, second_y0, second_y1, second_y1};
	assign ex1 = '{second_x1, second_x1, second_x0, second_x0};
	assign ey1 = '{second_y0, second_y1, second_y1, second_y0};

	always_comb begin
		c_in.act = action_t'(action);
		c_in.bad = 1'b0;
		c_in.inbox = 1'b0;
		case (action_t'(action))
			ACT_BOX_SEG: begin
				c_in.bad = (second_x0 > second_x1) || (second_y0 > second_y1);
				c_in.inbox = (second_x0 <= first_x0 && first_x0 <= second_x1 &&
					second_y0 <= first_y0 && first_y0 <= second_y1) ||
					(second_x0 <= first_x1 && first_x1 <= second_x1 &&
					second_y0 <= first_y1 && first_y1 <= second_y1);
			end
			ACT_BOX_BOX: begin
				c_in.bad = (first_x0 > first_x1) || (first_y0 > first_y1) ||
					(second_x0 > second_x1) || (second_y0 > second_y1);
				c_in.inbox = !(first_x1 < second_x0 || first_x0 > second_x1 ||
					first_y1 < second_y0 || first_y0 > second_y1);
			end
			default: ;
		endcase
	end

	sbit_segseg #(.CW(CW)) u_ss (.clk, .adv, .px0(first_x0), .py0(first_y0),
		.px1(first_x1), .py1(first_y1), .qx0(second_x0), .qy0(second_y0),
		.qx1(second_x1), .qy1(second_y1), .hit(seg_hit[4]));

	for (genvar g = 0; g < 4; g++) begin : g_edge
		sbit_segseg #(.CW(CW)) u_e (.clk, .adv, .px0(first_x0), .py0(first_y0),
			.px1(first_x1), .py1(first_y1), .qx0(ex0[g]), .qy0(ey0[g]),
			.qx1(ex1[g]), .qy1(ey1[g]), .hit(seg_hit[g]));
	end

	assign any = |seg_hit[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1 <= c_in;
			c_s2 <= c_s1;
			bad_s3 <= c_s2.bad;
			case (c_s2.act)
				ACT_SEG_SEG: hit_s3 <= seg_hit[4];
				ACT_BOX_SEG: hit_s3 <= !c_s2.bad && (c_s2.inbox || any);
				ACT_BOX_BOX: hit_s3 <= !c_s2.bad && c_s2.inbox;
				default:     hit_s3 <= 1'b0;
			endcase
		end
	end

	assign out_valid = v_s3;
	assign hit = hit_s3;
	assign bad_box = bad_s3;

	a_no_hit_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && bad_box)) else $error("hit with bad box");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(bad_box))
		else $error("output changed under stall");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##1 v_s1) else $error("beat lost");

endmodule

// ----- rtl/core/sbit_orient.sv -----
// One orientation test: sign of (b - a) x (c - a), two register stages.
module sbit_orient #(
	parameter int CW = 16
) (
	input  logic                clk,
	input  logic                adv,
	input  logic signed [CW-1:0] ax,
	input  logic signed [CW-1:0] ay,
	input  logic signed [CW-1:0] bx,
	input  logic signed [CW-1:0] by,
	input  logic signed [CW-1:0] cx,
	input  logic signed [CW-1:0] cy,
	output sbit_pkg::osign_t     sgn
);
	import sbit_pkg::*;

	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;

	logic signed [DW-1:0] d1_s1, d2_s1, d3_s1, d4_s1;
	logic signed [PW-1:0] p1_s2, p2_s2;
	logic signed [PW:0]   diff;

	always_ff @(posedge clk) begin
		if (adv) begin
			d1_s1 <= DW'(bx) - DW'(ax);
			d2_s1 <= DW'(cy) - DW'(ay);
			d3_s1 <= DW'(by) - DW'(ay);
			d4_s1 <= DW'(cx) - DW'(ax);
			p1_s2 <= PW'(d1_s1) * PW'(d2_s1);
			p2_s2 <= PW'(d3_s1) * PW'(d4_s1);
		end
	end

	assign diff = (PW+1)'(p1_s2) - (PW+1)'(p2_s2);
	assign sgn.pos = !diff[PW] && (diff != '0);
	assign sgn.neg = diff[PW];

endmodule

// ----- rtl/core/sbit_segseg.sv -----
// Segment-segment test: four orientations plus collinear range checks.
module sbit_segseg #(
	parameter int CW = 16
) (
	input  logic                 clk,
	input  logic                 adv,
	input  logic signed [CW-1:0] px0,
	input  logic signed [CW-1:0] py0,
	input  logic signed [CW-1:0] px1,
	input  logic signed [CW-1:0] py1,
	input  logic signed [CW-1:0] qx0,
	input  logic signed [CW-1:0] qy0,
	input  logic signed [CW-1:0] qx1,
	input  logic signed [CW-1:0] qy1,
	output logic                 hit
);
	import sbit_pkg::*;

	osign_t o1, o2, o3, o4;
	logic [3:0] rng_s1, rng_s2;

	function automatic logic rng(input logic signed [CW-1:0] ax, ay, bx, by, qx, qy);
		logic xok, yok;
		begin
			xok = (ax <= bx) ? (ax <= qx && qx <= bx) : (bx <= qx && qx <= ax);
			yok = (ay <= by) ? (ay <= qy && qy <= by) : (by <= qy && qy <= ay);
			return xok && yok;
		end
	endfunction

	sbit_orient #(.CW(CW)) u_o1 (.clk, .adv, .ax(px0), .ay(py0), .bx(px1), .by(py1),
		.cx(qx0), .cy(qy0), .sgn(o1));
	sbit_orient #(.CW(CW)) u_o2 (.clk, .adv, .ax(px0), .ay(py0), .bx(px1), .by(py1),
		.cx(qx1), .cy(qy1), .sgn(o2));
	sbit_orient #(.CW(CW)) u_o3 (.clk, .adv, .ax(qx0), .ay(qy0), .bx(qx1), .by(qy1),
		.cx(px0), .cy(py0), .sgn(o3));
	sbit_orient #(.CW(CW)) u_o4 (.clk, .adv, .ax(qx0), .ay(qy0), .bx(qx1), .by(qy1),
		.cx(px1), .cy(py1), .sgn(o4));

	always_ff @(posedge clk) begin
		if (adv) begin
			rng_s1 <= {rng(qx0, qy0, qx1, qy1, px1, py1), rng(qx0, qy0, qx1, qy1, px0, py0),
				rng(px0, py0, px1, py1, qx1, qy1), rng(px0, py0, px1, py1, qx0, qy0)};
			rng_s2 <= rng_s1;
		end
	end

	assign hit = ((o1.pos && o2.neg) || (o1.neg && o2.pos)) &&
		((o3.pos && o4.neg) || (o3.neg && o4.pos)) ||
		(!o1.pos && !o1.neg && rng_s2[0]) || (!o2.pos && !o2.neg && rng_s2[1]) ||
		(!o3.pos && !o3.neg && rng_s2[2]) || (!o4.pos && !o4.neg && rng_s2[3]);

endmodule
